// ===== rtl/tjp_pkg.sv =====
// shared types and constants for the jump pointer tree engine
// used by tree_jump_pointer_lca_distance; no dependencies
package tjp_pkg;

   localparam int NODE_W     = 16;
   localparam int DEPTH_W    = 16;
   localparam int NODE_COUNT = 65536;
   localparam int HOP_W      = 17;
   localparam int FUNC_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ROOT = 2'd0,
      FUNC_LEAF = 2'd1,
      FUNC_DIST = 2'd2,
      FUNC_KTH  = 2'd3
   } func_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [NODE_W-1:0]  parent;
      logic [NODE_W-1:0]  jump;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/tjp_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module tjp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd0_addr,
   output logic [WIDTH-1:0]         rd0_data,
   input  logic [$clog2(DEPTH)-1:0] rd1_addr,
   output logic [WIDTH-1:0]         rd1_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_data <= mem[rd0_addr];
      rd1_data <= mem[rd1_addr];
   end

endmodule

// ===== rtl/tree_jump_pointer_lca_distance.sv =====
// rooted tree engine with skew-binary jump pointers: set root, add leaf,
// lowest common ancestor with path length, k-th ancestor
// depends on tjp_pkg and tjp_ram
//
// usage:
//   requests enter on req_ (tuser = operation, tdata = node_a, node_b, steps).
//   set root and add leaf give no response; the two queries give one
//   response on rsp_ (tdata = result_node, path_length).
//   one request is worked at a time; req_tready is high only when idle.
//   set root writes its entry as the request is taken; add leaf makes three dependent reads and then writes.
//   a query reads both nodes and then walks the tree in hops along the jump
//   pointers, the walk being about twice log2 of the depth long; each hop is
//   one read of the node table through its two read ports plus one decision state.
//   the response sits in an output register; a new request is taken while
//   it waits, and only a second finished response stalls behind it.
//   reset clears the control state only; the node table is not cleared, and the user
//   must see that entries are read only after they were written; the block does not check this.
module tree_jump_pointer_lca_distance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // node_a[15:0], node_b[31:16], steps[47:32]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // result_node[15:0], path_length[31:16]
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEAF_B,
      S_LEAF_J1,
      S_LEAF_J2,
      S_Q_READ,
      S_CL_CHECK,
      S_CL_TAKE,
      S_LCA_CHECK,
      S_LCA_TAKE,
      S_DONE
   } state_type;

   localparam int NW = tjp_pkg::NODE_W;
   localparam int DW = tjp_pkg::DEPTH_W;
   localparam int HW = tjp_pkg::HOP_W;

   state_type            state_ff, state_in;
   tjp_pkg::func_type    func_ff, func_in;
   logic [NW-1:0]        a_ff, a_in;
   logic [NW-1:0]        b_ff, b_in;
   logic [DW-1:0]        steps_ff, steps_in;
   tjp_pkg::entry_type   cur_ff, cur_in;
   tjp_pkg::entry_type   bent_ff, bent_in;
   logic [DW-1:0]        target_ff, target_in;
   logic [HW-1:0]        hops_ff, hops_in;
   logic [DW-1:0]        da_ff, da_in;
   logic [DW-1:0]        db_ff, db_in;
   logic [NW-1:0]        res_node_ff, res_node_in;
   logic [DW-1:0]        res_len_ff, res_len_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]          rsp_tdata_ff, rsp_tdata_in;

   logic                 wr_en;
   logic [NW-1:0]        wr_addr;
   tjp_pkg::entry_type   wr_entry;
   logic [NW-1:0]        rd0_addr, rd1_addr;
   logic [tjp_pkg::ENTRY_W-1:0] rd0_raw, rd1_raw;
   tjp_pkg::entry_type   rd0, rd1;

   logic                 req_fire;
   tjp_pkg::func_type    req_func;
   logic [NW-1:0]        req_a, req_b;
   logic [DW-1:0]        req_steps;
   logic [DW-1:0]        leaf_depth;
   logic [DW:0]          leaf_twice, leaf_sum;
   logic [DW+1:0]        len_sum, len_twice, len_diff;

   tjp_ram #(
      .WIDTH (tjp_pkg::ENTRY_W),
      .DEPTH (tjp_pkg::NODE_COUNT)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_entry),
      .rd0_addr (rd0_addr),
      .rd0_data (rd0_raw),
      .rd1_addr (rd1_addr),
      .rd1_data (rd1_raw)
   );

   assign rd0        = tjp_pkg::entry_type'(rd0_raw);
   assign rd1        = tjp_pkg::entry_type'(rd1_raw);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_func   = tjp_pkg::func_type'(req_tuser);
   assign req_a      = req_tdata[15:0];
   assign req_b      = req_tdata[31:16];
   assign req_steps  = req_tdata[47:32];
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // add leaf: saturating depth and skew-binary jump test
   assign leaf_depth = (cur_ff.depth == {DW{1'b1}}) ? cur_ff.depth : cur_ff.depth + 1'b1;
   assign leaf_twice = {bent_ff.depth, 1'b0};
   assign leaf_sum   = {1'b0, rd0.depth} + {1'b0, cur_ff.depth};

   // path length, clamped
   assign len_sum   = {2'b00, da_ff} + {2'b00, db_ff};
   assign len_twice = {1'b0, cur_ff.depth, 1'b0};
   assign len_diff  = len_sum - len_twice;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      steps_in      = steps_ff;
      cur_in        = cur_ff;
      bent_in       = bent_ff;
      target_in     = target_ff;
      hops_in       = hops_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      res_node_in   = res_node_ff;
      res_len_in    = res_len_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = a_ff;
      wr_entry      = '{depth: leaf_depth, parent: b_ff, jump: b_ff};
      rd0_addr      = a_ff;
      rd1_addr      = b_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd0_addr = req_a;
            rd1_addr = req_b;
            if (req_fire) begin
               func_in  = req_func;
               a_in     = req_a;
               b_in     = req_b;
               steps_in = req_steps;
               unique case (req_func)
                  tjp_pkg::FUNC_ROOT: begin
                     wr_en    = 1'b1;
                     wr_addr  = req_a;
                     wr_entry = '{depth: '0, parent: req_a, jump: req_a};
                  end
                  tjp_pkg::FUNC_LEAF: begin
                     rd0_addr = req_b;
                     state_in = S_LEAF_B;
                  end
                  tjp_pkg::FUNC_DIST,
                  tjp_pkg::FUNC_KTH: begin
                     state_in = S_Q_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_LEAF_B: begin
            cur_in   = rd0;
            rd0_addr = rd0.jump;
            state_in = S_LEAF_J1;
         end

         S_LEAF_J1: begin
            bent_in  = rd0;
            rd0_addr = rd0.jump;
            state_in = S_LEAF_J2;
         end

         S_LEAF_J2: begin
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_entry = '{depth: leaf_depth, parent: b_ff,
                         jump: (leaf_twice == leaf_sum) ? bent_ff.jump : b_ff};
            state_in = S_IDLE;
         end

         S_Q_READ: begin
            hops_in  = '0;
            state_in = S_CL_CHECK;
            if (func_ff == tjp_pkg::FUNC_DIST) begin
               da_in = rd0.depth;
               db_in = rd1.depth;
               if (rd0.depth < rd1.depth) begin
                  cur_in    = rd1;
                  bent_in   = rd0;
                  a_in      = b_ff;
                  b_in      = a_ff;
                  target_in = rd0.depth;
               end else begin
                  cur_in    = rd0;
                  bent_in   = rd1;
                  target_in = rd1.depth;
               end
            end else begin
               cur_in    = rd0;
               target_in = (rd0.depth > steps_ff) ? rd0.depth - steps_ff : '0;
            end
         end

         S_CL_CHECK: begin
            rd0_addr = cur_ff.jump;
            rd1_addr = cur_ff.parent;
            if (cur_ff.depth > target_ff && !hops_ff[HW-1]) begin
               hops_in  = hops_ff + 1'b1;
               state_in = S_CL_TAKE;
            end else if (func_ff == tjp_pkg::FUNC_KTH) begin
               res_node_in = a_ff;
               res_len_in  = '0;
               state_in    = S_DONE;
            end else begin
               hops_in  = '0;
               state_in = S_LCA_CHECK;
            end
         end

         S_CL_TAKE: begin
            if (rd0.depth >= target_ff) begin
               cur_in = rd0;
               a_in   = cur_ff.jump;
            end else begin
               cur_in = rd1;
               a_in   = cur_ff.parent;
            end
            state_in = S_CL_CHECK;
         end

         S_LCA_CHECK: begin
            if (cur_ff.jump != bent_ff.jump) begin
               rd0_addr = cur_ff.jump;
               rd1_addr = bent_ff.jump;
            end else begin
               rd0_addr = cur_ff.parent;
               rd1_addr = bent_ff.parent;
            end
            if (a_ff != b_ff && !hops_ff[HW-1]) begin
               a_in     = rd0_addr;
               b_in     = rd1_addr;
               hops_in  = hops_ff + 1'b1;
               state_in = S_LCA_TAKE;
            end else begin
               res_node_in = a_ff;
               if (len_sum < len_twice) begin
                  res_len_in = '0;
               end else if (len_diff[DW+1:DW] != 2'b00) begin
                  res_len_in = {DW{1'b1}};
               end else begin
                  res_len_in = len_diff[DW-1:0];
               end
               state_in = S_DONE;
            end
         end

         S_LCA_TAKE: begin
            cur_in   = rd0;
            bent_in  = rd1;
            state_in = S_LCA_CHECK;
         end

         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_len_ff, res_node_ff};
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      func_ff     <= func_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      steps_ff    <= steps_in;
      cur_ff      <= cur_in;
      bent_ff     <= bent_in;
      target_ff   <= target_in;
      hops_ff     <= hops_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      res_node_ff <= res_node_in;
      res_len_ff  <= res_len_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

// ===== test/tb_top.sv =====
// testbench for tree_jump_pointer_lca_distance: grows random forests and one long chain,
// checks every lca, path length and k-th ancestor response against a tree predictor
// depends on tjp_pkg and the rtl of tree_jump_pointer_lca_distance
module tb_top;

   localparam int WALK_LIMIT   = 65536;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CHAIN_LEN    = 300;
   localparam int STALL_LIMIT  = 600000;
   localparam int IDLE_PERCENT = 17;
   localparam int SETTLE       = 200;

   typedef struct {
      tjp_pkg::func_type kind;
      bit [15:0]         node;
      bit [15:0]         length;
   } answer_type;

   class lca_scoreboard_type;
      bit [15:0] depth_mem  [0:65535];
      bit [15:0] parent_mem [0:65535];
      bit [15:0] jump_mem   [0:65535];
      answer_type answers[$];
      int errors = 0;
      int checked = 0;
      int roots = 0;
      int leaves = 0;
      int dists = 0;
      int kths = 0;
      int max_depth = 0;

      function int unsigned climb(int unsigned n, int unsigned target);
         int unsigned hops = 0;
         while (depth_mem[n] > target && hops < WALK_LIMIT) begin
            if (depth_mem[jump_mem[n]] >= target) n = jump_mem[n];
            else n = parent_mem[n];
            hops++;
         end
         return n;
      endfunction

      function int unsigned common_ancestor(int unsigned a, int unsigned b);
         int unsigned hops = 0;
         int unsigned t;
         if (depth_mem[a] < depth_mem[b]) begin
            t = a;
            a = b;
            b = t;
         end
         a = climb(a, depth_mem[b]);
         while (a != b && hops < WALK_LIMIT) begin
            if (jump_mem[a] != jump_mem[b]) begin
               a = jump_mem[a];
               b = jump_mem[b];
            end else begin
               a = parent_mem[a];
               b = parent_mem[b];
            end
            hops++;
         end
         return a;
      endfunction

      function void note_request(tjp_pkg::func_type f, bit [15:0] a, bit [15:0] b,
                                 bit [15:0] k);
         int unsigned du, j1, j2, nd, lca, target;
         bit [15:0] jp;
         longint len;
         answer_type rec;
         case (f)
            tjp_pkg::FUNC_ROOT: begin
               parent_mem[a] = a;
               jump_mem[a] = a;
               depth_mem[a] = '0;
               roots++;
            end
            tjp_pkg::FUNC_LEAF: begin
               du = depth_mem[b];
               j1 = jump_mem[b];
               j2 = jump_mem[j1];
               nd = (du >= 65535) ? 65535 : du + 1;
               jp = (2 * depth_mem[j1] == depth_mem[j2] + du) ? 16'(j2) : b;
               parent_mem[a] = b;
               depth_mem[a] = 16'(nd);
               jump_mem[a] = jp;
               if (nd > max_depth) max_depth = nd;
               leaves++;
            end
            tjp_pkg::FUNC_DIST: begin
               lca = common_ancestor(a, b);
               len = longint'(depth_mem[a]) + longint'(depth_mem[b])
                     - 2 * longint'(depth_mem[lca]);
               if (len < 0) len = 0;
               if (len > 65535) len = 65535;
               rec.kind = f;
               rec.node = 16'(lca);
               rec.length = 16'(len);
               answers = {answers, rec};
               dists++;
            end
            default: begin
               target = (depth_mem[a] > k) ? depth_mem[a] - k : 0;
               rec.kind = f;
               rec.node = 16'(climb(a, target));
               rec.length = '0;
               answers = {answers, rec};
               kths++;
            end
         endcase
      endfunction

      function void check_response(logic [31:0] data);
         answer_type want;
         if (answers.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none actual %h",
                     $time, data);
            errors++;
            return;
         end
         want = answers.pop_front();
         checked++;
         if (data[15:0] !== want.node) begin
            $display("%0t: %s result_node mismatch, expected %0d actual %0d",
                     $time, want.kind.name(), want.node, data[15:0]);
            errors++;
         end
         if (data[31:16] !== want.length) begin
            $display("%0t: %s path_length mismatch, expected %0d actual %0d",
                     $time, want.kind.name(), want.length, data[31:16]);
            errors++;
         end
      endfunction

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   bit        sender_idle = 1'b1;
   bit        receiver_idle = 1'b1;
   int        stall_cycles = 0;
   int        phase_id = 0;
   int        tree_tag [0:65535];
   bit [15:0] members[$];
   bit [15:0] written_ids[$];
   bit [15:0] newest;
   lca_scoreboard_type sb = new();

   tree_jump_pointer_lca_distance uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= !receiver_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, stall_cycles);
            $display("tb_top failed");
            $finish;
         end
      end
   end

   function automatic bit [15:0] any16();
      return 16'($urandom);
   endfunction

   function automatic bit [15:0] fresh_node();
      bit [15:0] id;
      do begin
         id = any16();
      end while (tree_tag[id] == phase_id);
      return id;
   endfunction

   function automatic bit [15:0] pick_member();
      return members[$urandom_range(0, members.size() - 1)];
   endfunction

   function automatic bit [15:0] climb_steps();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 16'($urandom_range(0, 3));
      if (roll < 75) return 16'($urandom_range(0, 80));
      if (roll < 90) return 16'hFFFF;
      return any16();
   endfunction

   task automatic send_request(tjp_pkg::func_type f, bit [15:0] a, bit [15:0] b,
                               bit [15:0] k);
      while (sender_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {k, b, a};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(f, a, b, k);
      if (f == tjp_pkg::FUNC_ROOT || f == tjp_pkg::FUNC_LEAF) written_ids = {written_ids, a};
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic grow_member(bit [15:0] parent);
      bit [15:0] leaf;
      leaf = fresh_node();
      send_request(tjp_pkg::FUNC_LEAF, leaf, parent, any16());
      members = {members, leaf};
      tree_tag[leaf] = phase_id;
      newest = leaf;
   endtask

   initial begin
      bit [15:0] a_node, b_node, base;
      int roll, chain_bias, n_items, random_items;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // small hand-built tree, extremes of the node range
      send_request(tjp_pkg::FUNC_ROOT, 16'hFFFF, any16(), any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd0, 16'hFFFF, any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd1, 16'd0, any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd2, 16'd1, any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd3, 16'd2, any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd4, 16'd0, any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'd5, 16'd4, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'd3, 16'd5, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'd5, 16'd3, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'd3, 16'd3, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'd1, 16'd3, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'hFFFF, 16'd5, any16());
      send_request(tjp_pkg::FUNC_KTH, 16'd3, any16(), 16'd0);
      send_request(tjp_pkg::FUNC_KTH, 16'd3, any16(), 16'd2);
      send_request(tjp_pkg::FUNC_KTH, 16'd3, any16(), 16'd4);
      send_request(tjp_pkg::FUNC_KTH, 16'd3, any16(), 16'hFFFF);
      send_request(tjp_pkg::FUNC_KTH, 16'hFFFF, any16(), 16'd1);
      // second root: a query across the two trees runs into the walk limit
      send_request(tjp_pkg::FUNC_ROOT, 16'h8000, any16(), any16());
      send_request(tjp_pkg::FUNC_LEAF, 16'h7FFF, 16'h8000, any16());
      send_request(tjp_pkg::FUNC_DIST, 16'h7FFF, 16'd3, any16());
      send_request(tjp_pkg::FUNC_KTH, 16'h7FFF, any16(), 16'd1);

      // random forests, one well-formed tree per phase plus some stray writes
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase_id++;
         sender_idle = (phase_id % 5 != 3);
         receiver_idle = sender_idle;
         members.delete();
         a_node = fresh_node();
         send_request(tjp_pkg::FUNC_ROOT, a_node, any16(), any16());
         members = {members, a_node};
         tree_tag[a_node] = phase_id;
         newest = a_node;
         random_items++;
         chain_bias = $urandom_range(0, 90);
         n_items = $urandom_range(20, 150);
         repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               grow_member(($urandom_range(0, 99) < chain_bias) ? newest : pick_member());
               random_items++;
            end else if (roll < 70) begin
               a_node = pick_member();
               b_node = ($urandom_range(0, 4) == 0) ? a_node : pick_member();
               send_request(tjp_pkg::FUNC_DIST, a_node, b_node, any16());
               random_items++;
            end else if (roll < 95) begin
               send_request(tjp_pkg::FUNC_KTH, pick_member(), any16(), climb_steps());
               random_items++;
            end else if (roll < 97) begin
               send_request(tjp_pkg::FUNC_ROOT, fresh_node(), any16(), any16());
            end else begin
               b_node = written_ids[$urandom_range(0, written_ids.size() - 1)];
               send_request(tjp_pkg::FUNC_LEAF, fresh_node(), b_node, any16());
            end
         end
         if (phase_id == 2 || $urandom_range(0, 3) == 0) drain();
      end

      // one long chain for deep jump pointer walks, no idling
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      base = any16();
      send_request(tjp_pkg::FUNC_ROOT, base, any16(), any16());
      for (int k = 1; k < CHAIN_LEN; k++) begin
         send_request(tjp_pkg::FUNC_LEAF, 16'(base + k), 16'(base + k - 1), any16());
         if (k % 32 == 0) begin
            send_request(tjp_pkg::FUNC_DIST, 16'(base + $urandom_range(0, k)),
                         16'(base + $urandom_range(0, k)), any16());
            send_request(tjp_pkg::FUNC_KTH, 16'(base + k), any16(), climb_steps());
         end
      end
      send_request(tjp_pkg::FUNC_DIST, 16'(base + CHAIN_LEN - 1), base, any16());
      send_request(tjp_pkg::FUNC_KTH, 16'(base + CHAIN_LEN - 1), any16(), 16'hFFFF);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d set-root, %0d add-leaf, %0d distance, %0d k-th ancestor requests",
               sb.roots, sb.leaves, sb.dists, sb.kths);
      $display("deepest node at depth %0d, %0d responses checked, %0d mismatches",
               sb.max_depth, sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
